@@ design/qkw_pkg.sv @@
package qkw_pkg;

  localparam int EXT_W    = 31;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_DIST = 2'd1,
    ST_ZERO_EXT  = 2'd2
  } status_t;

  typedef struct packed {
    logic       last;
    logic       h_zero;
    logic       s_zero;
    logic       w_over;
    logic [2:0] neg;
  } flags_t;

endpackage

@@ design/qkw_front.sv @@
module qkw_front #(
  parameter int CW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [CW-1:0]               px,
  input  logic [CW-1:0]               py,
  input  logic [CW-1:0]               pz,
  input  logic [qkw_pkg::EXT_W-1:0]   extent,
  input  logic [CW-1:0]               ex,
  input  logic [CW-1:0]               ey,
  input  logic [CW-1:0]               ez,
  input  logic                        last,
  output logic                        out_valid,
  output logic [2*(CW+1)-1:0]         s,
  output logic [2*qkw_pkg::EXT_W+1:0] rem4,
  output logic [2*qkw_pkg::EXT_W-1:0] h2,
  output logic [qkw_pkg::EXT_W-1:0]   h,
  output logic [CW:0]                 mag_x,
  output logic [CW:0]                 mag_y,
  output logic [CW:0]                 mag_z,
  output qkw_pkg::flags_t             flags
);

  localparam int EW   = qkw_pkg::EXT_W;
  localparam int MAGW = CW + 1;
  localparam int SW   = 2 * MAGW;
  localparam int H2W  = 2 * EW;
  localparam int FH2W = H2W + 2;

  // stage 1: differences
  logic            v1;
  logic [MAGW-1:0] d_x, d_y, d_z;
  logic [EW-1:0]   h1;
  logic            last1;

  // stage 2: magnitudes squared
  logic            v2;
  logic [SW-1:0]   sq_x, sq_y, sq_z;
  logic [MAGW-1:0] m2_x, m2_y, m2_z;
  logic [H2W-1:0]  h2_2;
  logic [EW-1:0]   h_2;
  logic [2:0]      neg2;
  logic            hz2;
  logic            last2;

  logic [MAGW-1:0] mx_next, my_next, mz_next;
  logic [SW-1:0]   s_next;
  logic [FH2W-1:0] four_h2;

  assign mx_next = d_x[MAGW-1] ? MAGW'(-d_x) : d_x;
  assign my_next = d_y[MAGW-1] ? MAGW'(-d_y) : d_y;
  assign mz_next = d_z[MAGW-1] ? MAGW'(-d_z) : d_z;

  assign s_next  = sq_x + sq_y + sq_z;
  assign four_h2 = {h2_2, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_x   <= {px[CW-1], px} - {ex[CW-1], ex};
      d_y   <= {py[CW-1], py} - {ey[CW-1], ey};
      d_z   <= {pz[CW-1], pz} - {ez[CW-1], ez};
      h1    <= extent;
      last1 <= last;

      sq_x  <= mx_next * mx_next;
      sq_y  <= my_next * my_next;
      sq_z  <= mz_next * mz_next;
      m2_x  <= mx_next;
      m2_y  <= my_next;
      m2_z  <= mz_next;
      h2_2  <= h1 * h1;
      h_2   <= h1;
      neg2  <= {d_z[MAGW-1], d_y[MAGW-1], d_x[MAGW-1]};
      hz2   <= (h1 == '0);
      last2 <= last1;

      s            <= s_next;
      rem4         <= four_h2 - FH2W'(s_next);
      h2           <= h2_2;
      h            <= h_2;
      mag_x        <= m2_x;
      mag_y        <= m2_y;
      mag_z        <= m2_z;
      flags.last   <= last2;
      flags.h_zero <= hz2;
      flags.s_zero <= (s_next == '0);
      flags.w_over <= (s_next >= SW'(four_h2));
      flags.neg    <= neg2;
    end
  end

endmodule

@@ design/qkw_sqrt.sv @@
module qkw_sqrt #(
  parameter int RW  = 33,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] s,
  input  logic [SBW-1:0]  sb_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SBW-1:0]  sb_out
);

  // one root bit per stage, two radicand bits consumed per stage
  logic [RW-1:0]   root_r [RW];
  logic [SBW-1:0]  sb_r   [RW];
  logic            v_r    [RW];
  logic [RW-1:0]   rem_r  [RW-1];
  logic [2*RW-1:0] s_r    [RW-1];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW-1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] s_i;
    logic [SBW-1:0]  sb_i;
    logic            v_i;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s;
      assign sb_i   = sb_in;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign s_i    = s_r[i-1];
      assign sb_i   = sb_r[i-1];
      assign v_i    = v_r[i-1];
    end

    assign rem_sh = {rem_i, s_i[2*RW-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_i[RW-2:0], ge};
        sb_r[i]   <= sb_i;
      end
    end

    if (i < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
          s_r[i]   <= {s_i[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];
  assign sb_out    = sb_r[RW-1];

endmodule

@@ design/qkw_div.sv @@
module qkw_div #(
  parameter int DENW = 64,
  parameter int QW   = 32,
  parameter int SBW  = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DENW-1:0] rem0,
  input  logic [QW-1:0]   low,
  input  logic [DENW-1:0] den,
  input  logic [SBW-1:0]  sb_in,
  output logic            out_valid,
  output logic [QW-1:0]   q,
  output logic [SBW-1:0]  sb_out
);

  // restoring division, one quotient bit per stage; rem0 < den on entry
  logic [QW-1:0]   q_r   [QW];
  logic [SBW-1:0]  sb_r  [QW];
  logic            v_r   [QW];
  logic [DENW-1:0] rem_r [QW-1];
  logic [QW-1:0]   low_r [QW-1];
  logic [DENW-1:0] den_r [QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DENW-1:0] rem_i;
    logic [QW-1:0]   low_i;
    logic [DENW-1:0] den_i;
    logic [QW-1:0]   q_i;
    logic [SBW-1:0]  sb_i;
    logic            v_i;
    logic [DENW:0]   r_sh;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_i = rem0;
      assign low_i = low;
      assign den_i = den;
      assign q_i   = '0;
      assign sb_i  = sb_in;
      assign v_i   = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[i-1];
      assign low_i = low_r[i-1];
      assign den_i = den_r[i-1];
      assign q_i   = q_r[i-1];
      assign sb_i  = sb_r[i-1];
      assign v_i   = v_r[i-1];
    end

    assign r_sh = {rem_i, low_i[QW-1]};
    assign ge   = (r_sh >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]  <= {q_i[QW-2:0], ge};
        sb_r[i] <= sb_i;
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? DENW'(r_sh - {1'b0, den_i}) : DENW'(r_sh);
          low_r[i] <= {low_i[QW-2:0], 1'b0};
          den_r[i] <= den_i;
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign q         = q_r[QW-1];
  assign sb_out    = sb_r[QW-1];

endmodule

@@ design/quadratic_kernel_weight.sv @@
// Channel  | Dir | tdata, low bit first                                   | tuser/tlast
// s_*      | in  | point_x, point_y, point_z, extent, eval_x, eval_y, eval_z | tlast = last
// m_*      | out | weight, grad_x, grad_y, grad_z, status                  | tlast = last_out
//
// One request per cycle while m_tready does not stall the pipeline; the pipeline depth is set by
// the bit-per-stage square root (COORD_WIDTH+1 stages) and the bit-per-stage dividers.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// A stall on m_tready freezes the whole pipeline; nothing moves, nothing is lost.
// s_tready is high whenever the output register is empty or being taken.
module quadratic_kernel_weight #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // point_x, point_y, point_z, extent, eval_x, eval_y, eval_z, zero fill
  input  logic [((6*COORD_WIDTH+qkw_pkg::EXT_W+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // weight, grad_x, grad_y, grad_z, status, zero fill
  output logic [((FRAC_BITS+3+3*COORD_WIDTH+qkw_pkg::STATUS_W+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int EW   = qkw_pkg::EXT_W;
  localparam int MAGW = CW + 1;
  localparam int SW   = 2 * MAGW;
  localparam int RW   = MAGW;
  localparam int H2W  = 2 * EW;
  localparam int FH2W = H2W + 2;
  localparam int DHW  = RW + EW;
  localparam int WW   = FB + 3;
  localparam int QW   = (CW > WW) ? CW : WW;
  localparam int GNW  = MAGW + 2 * FB;
  localparam int WNW  = FH2W + FB;
  localparam int FLW  = $bits(qkw_pkg::flags_t);
  localparam int SBW  = FLW + FH2W + H2W + EW + 3 * MAGW;
  localparam int OUTW = ((WW + 3*CW + qkw_pkg::STATUS_W + 7) / 8) * 8;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front: differences, squares, sum of squares
  logic                   fr_valid;
  logic [SW-1:0]          fr_s;
  logic [FH2W-1:0]        fr_rem4;
  logic [H2W-1:0]         fr_h2;
  logic [EW-1:0]          fr_h;
  logic [MAGW-1:0]        fr_mx, fr_my, fr_mz;
  qkw_pkg::flags_t        fr_flags;

  qkw_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .px       (s_tdata[CW-1:0]),
    .py       (s_tdata[2*CW-1:CW]),
    .pz       (s_tdata[3*CW-1:2*CW]),
    .extent   (s_tdata[3*CW+EW-1:3*CW]),
    .ex       (s_tdata[4*CW+EW-1:3*CW+EW]),
    .ey       (s_tdata[5*CW+EW-1:4*CW+EW]),
    .ez       (s_tdata[6*CW+EW-1:5*CW+EW]),
    .last     (s_tlast),
    .out_valid(fr_valid),
    .s        (fr_s),
    .rem4     (fr_rem4),
    .h2       (fr_h2),
    .h        (fr_h),
    .mag_x    (fr_mx),
    .mag_y    (fr_my),
    .mag_z    (fr_mz),
    .flags    (fr_flags)
  );

  // distance
  logic                   sq_valid;
  logic [RW-1:0]          sq_root;
  logic [SBW-1:0]         sq_sb_in, sq_sb_out;
  qkw_pkg::flags_t        sq_flags;
  logic [FH2W-1:0]        sq_rem4;
  logic [H2W-1:0]         sq_h2;
  logic [EW-1:0]          sq_h;
  logic [MAGW-1:0]        sq_mx, sq_my, sq_mz;

  assign sq_sb_in = {fr_flags, fr_rem4, fr_h2, fr_h, fr_mx, fr_my, fr_mz};
  assign {sq_flags, sq_rem4, sq_h2, sq_h, sq_mx, sq_my, sq_mz} = sq_sb_out;

  qkw_sqrt #(.RW(RW), .SBW(SBW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fr_valid),
    .s        (fr_s),
    .sb_in    (sq_sb_in),
    .out_valid(sq_valid),
    .root     (sq_root),
    .sb_out   (sq_sb_out)
  );

  // D*h
  logic                   m_valid;
  logic [DHW-1:0]         m_den;
  qkw_pkg::flags_t        m_flags;
  logic [FH2W-1:0]        m_rem4;
  logic [H2W-1:0]         m_h2;
  logic [MAGW-1:0]        m_mx, m_my, m_mz;

  // divider operands; gradient saturation when the quotient would reach 2^QW
  logic                   p_valid;
  qkw_pkg::flags_t        p_flags;
  logic [H2W-1:0]         p_h2, p_rem0_w;
  logic [QW-1:0]          p_low_w;
  logic [DHW-1:0]         p_den;
  logic [DHW-1:0]         p_rem0_x, p_rem0_y, p_rem0_z;
  logic [QW-1:0]          p_low_x, p_low_y, p_low_z;
  logic [2:0]             p_sat;

  logic [WNW-1:0]         nw;
  logic [GNW-1:0]         ng_x, ng_y, ng_z;
  logic [GNW-1:0]         ngh_x, ngh_y, ngh_z;

  assign nw    = {m_rem4, {FB{1'b0}}};
  assign ng_x  = {m_mx, {(2*FB){1'b0}}};
  assign ng_y  = {m_my, {(2*FB){1'b0}}};
  assign ng_z  = {m_mz, {(2*FB){1'b0}}};
  assign ngh_x = ng_x >> QW;
  assign ngh_y = ng_y >> QW;
  assign ngh_z = ng_z >> QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      m_valid <= sq_valid;
      p_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_den    <= sq_root * sq_h;
      m_flags  <= sq_flags;
      m_rem4   <= sq_rem4;
      m_h2     <= sq_h2;
      m_mx     <= sq_mx;
      m_my     <= sq_my;
      m_mz     <= sq_mz;

      p_flags  <= m_flags;
      p_h2     <= m_h2;
      p_rem0_w <= H2W'(nw >> QW);
      p_low_w  <= nw[QW-1:0];
      p_den    <= m_den;
      p_rem0_x <= DHW'(ngh_x);
      p_rem0_y <= DHW'(ngh_y);
      p_rem0_z <= DHW'(ngh_z);
      p_low_x  <= ng_x[QW-1:0];
      p_low_y  <= ng_y[QW-1:0];
      p_low_z  <= ng_z[QW-1:0];
      p_sat    <= {ngh_z >= GNW'(m_den), ngh_y >= GNW'(m_den), ngh_x >= GNW'(m_den)};
    end
  end

  // dividers
  logic                   dw_valid, dx_valid, dy_valid, dz_valid;
  logic [QW-1:0]          q_w, q_x, q_y, q_z;
  qkw_pkg::flags_t        d_flags;
  logic [1:0]             sb_x, sb_y, sb_z;

  qkw_div #(.DENW(H2W), .QW(QW), .SBW(FLW)) u_div_w (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .rem0(p_rem0_w), .low(p_low_w), .den(p_h2), .sb_in(p_flags),
    .out_valid(dw_valid), .q(q_w), .sb_out(d_flags)
  );

  qkw_div #(.DENW(DHW), .QW(QW), .SBW(2)) u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .rem0(p_rem0_x), .low(p_low_x), .den(p_den), .sb_in({p_sat[0], p_flags.neg[0]}),
    .out_valid(dx_valid), .q(q_x), .sb_out(sb_x)
  );

  qkw_div #(.DENW(DHW), .QW(QW), .SBW(2)) u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .rem0(p_rem0_y), .low(p_low_y), .den(p_den), .sb_in({p_sat[1], p_flags.neg[1]}),
    .out_valid(dy_valid), .q(q_y), .sb_out(sb_y)
  );

  qkw_div #(.DENW(DHW), .QW(QW), .SBW(2)) u_div_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .rem0(p_rem0_z), .low(p_low_z), .den(p_den), .sb_in({p_sat[2], p_flags.neg[2]}),
    .out_valid(dz_valid), .q(q_z), .sb_out(sb_z)
  );

  function automatic logic [CW-1:0] clamp_grad(input logic [QW-1:0] q,
                                               input logic [1:0] sb);
    logic [QW:0] lim;
    logic [QW:0] v;
    lim = sb[0] ? ((QW+1)'(1) << (CW - 1)) : (((QW+1)'(1) << (CW - 1)) - 1'b1);
    v   = (sb[1] || ({1'b0, q} > lim)) ? lim : {1'b0, q};
    return sb[0] ? CW'(-v) : CW'(v);
  endfunction

  logic                    grad_off;
  logic [WW-1:0]           weight, weight_next;
  logic [CW-1:0]           grad_x, grad_y, grad_z;
  qkw_pkg::status_t        status, status_next;

  assign grad_off = d_flags.h_zero || d_flags.s_zero;

  always_comb begin
    weight_next = (d_flags.h_zero || d_flags.w_over) ? '0 : WW'(q_w);
    if (d_flags.h_zero) begin
      status_next = qkw_pkg::ST_ZERO_EXT;
    end else if (d_flags.s_zero) begin
      status_next = qkw_pkg::ST_ZERO_DIST;
    end else begin
      status_next = qkw_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dw_valid && dx_valid && dy_valid && dz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight  <= weight_next;
      grad_x  <= grad_off ? '0 : clamp_grad(q_x, sb_x);
      grad_y  <= grad_off ? '0 : clamp_grad(q_y, sb_y);
      grad_z  <= grad_off ? '0 : clamp_grad(q_z, sb_z);
      status  <= status_next;
      m_tlast <= d_flags.last;
    end
  end

  assign m_tdata = OUTW'({status, grad_z, grad_y, grad_x, weight});

endmodule

@@ design/qkw_checker.sv @@
module qkw_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((FRAC_BITS+3+3*COORD_WIDTH+qkw_pkg::STATUS_W+7)/8)*8-1:0] m_tdata,
  input logic m_tlast
);

  localparam int CW = COORD_WIDTH;
  localparam int WW = FRAC_BITS + 3;
  localparam int SL = WW + 3 * CW;

  logic [WW-1:0]                  weight;
  logic [3*CW-1:0]                grads;
  logic [qkw_pkg::STATUS_W-1:0]   status;

  assign weight = m_tdata[WW-1:0];
  assign grads  = m_tdata[SL-1:WW];
  assign status = m_tdata[SL+qkw_pkg::STATUS_W-1:SL];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_take: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output register");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> weight <= (WW'(4) << FRAC_BITS))
    else $error("weight above 4.0");

  a_zext: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == qkw_pkg::ST_ZERO_EXT |-> weight == '0 && grads == '0)
    else $error("zero extent result not cleared");

  a_zdist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == qkw_pkg::ST_ZERO_DIST |->
      weight == (WW'(4) << FRAC_BITS) && grads == '0)
    else $error("zero distance result wrong");

endmodule

bind quadratic_kernel_weight qkw_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_qkw_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
